@@ hw/rtl/vpw_pkg.sv @@
// Shared types and constants for the VPW frame receiver.
// No dependencies; used by vpw_decode and vpw_frame_receiver.
package vpw_pkg;

	localparam int unsigned TimeW  = 10;
	localparam int unsigned MsW    = 8;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned BitCntW = 3;
	localparam int unsigned RegIdxW = 3;

	// Configuration register indexes
	typedef enum logic [RegIdxW-1:0] {
		REG_SOF_MIN        = 3'd0,
		REG_SOF_MAX        = 3'd1,
		REG_GLITCH         = 3'd2,
		REG_LONG_MIN       = 3'd3,
		REG_SYMBOL_TIMEOUT = 3'd4,
		REG_TICKS_PER_MS   = 3'd5,
		REG_IDLE_TIMEOUT   = 3'd6
	} reg_idx_t;

	// Reset values of the configuration registers
	localparam logic [TimeW-1:0] SOF_MIN_RST        = 10'd160;
	localparam logic [TimeW-1:0] SOF_MAX_RST        = 10'd232;
	localparam logic [TimeW-1:0] GLITCH_RST         = 10'd32;
	localparam logic [TimeW-1:0] LONG_MIN_RST       = 10'd96;
	localparam logic [TimeW-1:0] SYMBOL_TIMEOUT_RST = 10'd160;
	localparam logic [TimeW-1:0] TICKS_PER_MS_RST   = 10'd1000;
	localparam logic [MsW-1:0]   IDLE_TIMEOUT_RST   = 8'd100;

	localparam logic [TimeW-1:0] TICKS_MAX = '1;
	localparam logic [ByteW-1:0] BYTES_MAX = '1;

	// Result kinds and end reasons
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef enum logic [1:0] {
		END_SYMBOL_TIMEOUT = 2'd0,
		END_IDLE_TIMEOUT   = 2'd1,
		END_SOF_TOO_LONG   = 2'd2
	} end_reason_t;

	// Receiver phase, one-hot
	typedef enum logic [3:0] {
		PH_WAIT   = 4'b0001,
		PH_SOF    = 4'b0010,
		PH_SYMBOL = 4'b0100,
		PH_GLITCH = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [TimeW-1:0] sof_min;
		logic [TimeW-1:0] sof_max;
		logic [TimeW-1:0] glitch;
		logic [TimeW-1:0] long_min;
		logic [TimeW-1:0] symbol_timeout;
		logic [TimeW-1:0] ticks_per_ms;
		logic [MsW-1:0]   idle_timeout;
	} vpw_cfg_t;

	typedef struct packed {
		phase_t             phase;
		logic [TimeW-1:0]   elapsed;
		logic [MsW-1:0]     ms_left;
		logic               symbol_level;
		logic [ByteW-1:0]   shift_byte;
		logic [BitCntW-1:0] bits_taken;
		logic [ByteW-1:0]   bytes_taken;
	} vpw_state_t;

	typedef struct packed {
		logic               valid;
		logic               kind;
		logic [ByteW-1:0]   data;
		logic [ByteW-1:0]   count;
		end_reason_t        reason;
		logic [BitCntW-1:0] pending;
	} vpw_result_t;

	// Saturating tick counter increment
	function automatic logic [TimeW-1:0] bump(input logic [TimeW-1:0] v);
		return (v == TICKS_MAX) ? v : v + 1'b1;
	endfunction

endpackage

@@ hw/rtl/vpw_decode.sv @@
// Per-tick next-state and result logic of the VPW receiver.
// Depends on vpw_pkg.
module vpw_decode (
	input  vpw_pkg::vpw_cfg_t    cfg,
	input  vpw_pkg::vpw_state_t  cur,
	input  logic                 lvl,
	output vpw_pkg::vpw_state_t  nxt,
	output vpw_pkg::vpw_result_t res
);
	import vpw_pkg::*;

	logic [TimeW-1:0]   el_inc;
	logic [MsW-1:0]     ms_dec;
	logic               sym_bit;
	logic [ByteW-1:0]   shift_new;
	logic [ByteW-1:0]   bytes_inc;
	logic               fin;
	end_reason_t        fin_reason;
	logic [BitCntW-1:0] fin_pending;

	assign el_inc    = bump(cur.elapsed);
	assign ms_dec    = (cur.ms_left != '0) ? cur.ms_left - 1'b1 : cur.ms_left;
	// long low or short high decodes to 1
	assign sym_bit   = (cur.elapsed >= cfg.long_min) ? ~cur.symbol_level : cur.symbol_level;
	assign shift_new = {cur.shift_byte[ByteW-2:0], sym_bit};
	assign bytes_inc = (cur.bytes_taken != BYTES_MAX) ? cur.bytes_taken + 1'b1
		: cur.bytes_taken;

	// Phase transitions
	always_comb begin
		nxt         = cur;
		res         = '0;
		fin         = 1'b0;
		fin_reason  = END_SYMBOL_TIMEOUT;
		fin_pending = '0;
		case (cur.phase)
			PH_WAIT: begin
				if (lvl) begin
					nxt.phase   = PH_SOF;
					nxt.elapsed = TimeW'(1);
				end else if (el_inc >= cfg.ticks_per_ms) begin
					nxt.elapsed = '0;
					nxt.ms_left = ms_dec;
					if (ms_dec == '0) begin
						fin        = 1'b1;
						fin_reason = END_IDLE_TIMEOUT;
					end
				end else begin
					nxt.elapsed = el_inc;
				end
			end
			PH_SOF: begin
				if (lvl) begin
					nxt.elapsed = el_inc;
					if (el_inc >= cfg.sof_max) begin
						fin        = 1'b1;
						fin_reason = END_SOF_TOO_LONG;
					end
				end else if (cur.elapsed < cfg.sof_min) begin
					// start pulse too short: wait again, ms count kept
					nxt.phase   = PH_WAIT;
					nxt.elapsed = '0;
				end else begin
					nxt.phase        = PH_SYMBOL;
					nxt.symbol_level = 1'b0;
					nxt.elapsed      = TimeW'(1);
				end
			end
			PH_SYMBOL: begin
				if (lvl == cur.symbol_level || cur.elapsed < cfg.glitch) begin
					if (lvl != cur.symbol_level)
						nxt.phase = PH_GLITCH;
					nxt.elapsed = el_inc;
					if (el_inc >= cfg.symbol_timeout) begin
						fin         = 1'b1;
						fin_pending = cur.bits_taken;
					end
				end else begin
					nxt.symbol_level = lvl;
					nxt.elapsed      = TimeW'(1);
					nxt.bits_taken   = cur.bits_taken + 1'b1;
					nxt.shift_byte   = shift_new;
					if (cur.bits_taken == '1) begin
						nxt.shift_byte  = '0;
						nxt.bytes_taken = bytes_inc;
						res.valid       = 1'b1;
						res.kind        = KIND_BYTE;
						res.data        = shift_new;
						res.count       = bytes_inc;
					end
				end
			end
			PH_GLITCH: begin
				if (lvl == cur.symbol_level)
					nxt.phase = PH_SYMBOL;
				nxt.elapsed = el_inc;
				if (el_inc >= cfg.symbol_timeout) begin
					fin         = 1'b1;
					fin_pending = cur.bits_taken;
				end
			end
			default: begin
				nxt.phase       = PH_WAIT;
				nxt.elapsed     = '0;
				nxt.bits_taken  = '0;
				nxt.shift_byte  = '0;
				nxt.bytes_taken = '0;
			end
		endcase

		// Frame end: report and clear the frame
		if (fin) begin
			res.valid        = 1'b1;
			res.kind         = KIND_END;
			res.data         = '0;
			res.count        = cur.bytes_taken;
			res.reason       = fin_reason;
			res.pending      = fin_pending;
			nxt.phase        = PH_WAIT;
			nxt.elapsed      = '0;
			nxt.symbol_level = 1'b0;
			nxt.shift_byte   = '0;
			nxt.bits_taken   = '0;
			nxt.bytes_taken  = '0;
			nxt.ms_left      = cfg.idle_timeout;
		end
	end

endmodule

@@ hw/rtl/vpw_frame_receiver.sv @@
// Channel  Signals                    Dir  Notes
// in       in_valid/in_ready          in   rx_level, one request per bus tick
// out      out_valid/out_ready        out  result_kind, byte_data, byte_count,
//                                          end_reason, pending_bits
// cfg      cfg_we/cfg_index/cfg_data  in   register write, no wait
//
// One tick is taken per cycle while in_ready is high; its state update and result are
// registered and ready in the cycle after accept.
// A pending result sits in the output register; the next tick is still taken
// while out_ready is high, else in_ready drops until the result is taken.
// Reset (arst_n low) restores the register defaults and the wait phase.
// Depends on vpw_pkg and vpw_decode.
module vpw_frame_receiver (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          rx_level,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          result_kind,
	output logic [vpw_pkg::ByteW-1:0]     byte_data,
	output logic [vpw_pkg::ByteW-1:0]     byte_count,
	output logic [1:0]                    end_reason,
	output logic [vpw_pkg::BitCntW-1:0]   pending_bits,
	input  logic                          cfg_we,
	input  logic [vpw_pkg::RegIdxW-1:0]   cfg_index,
	input  logic [vpw_pkg::TimeW-1:0]     cfg_data
);
	import vpw_pkg::*;

	vpw_cfg_t    cfg_q;
	vpw_state_t  state_q;
	vpw_state_t  state_nxt;
	vpw_result_t res;
	vpw_result_t out_q;
	logic        in_acc;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sof_min        <= SOF_MIN_RST;
			cfg_q.sof_max        <= SOF_MAX_RST;
			cfg_q.glitch         <= GLITCH_RST;
			cfg_q.long_min       <= LONG_MIN_RST;
			cfg_q.symbol_timeout <= SYMBOL_TIMEOUT_RST;
			cfg_q.ticks_per_ms   <= TICKS_PER_MS_RST;
			cfg_q.idle_timeout   <= IDLE_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOF_MIN:        cfg_q.sof_min        <= cfg_data;
				REG_SOF_MAX:        cfg_q.sof_max        <= cfg_data;
				REG_GLITCH:         cfg_q.glitch         <= cfg_data;
				REG_LONG_MIN:       cfg_q.long_min       <= cfg_data;
				REG_SYMBOL_TIMEOUT: cfg_q.symbol_timeout <= cfg_data;
				REG_TICKS_PER_MS:   cfg_q.ticks_per_ms   <= cfg_data;
				REG_IDLE_TIMEOUT:   cfg_q.idle_timeout   <= cfg_data[MsW-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !out_q.valid || out_ready;
	assign in_acc   = in_valid && in_ready;

	vpw_decode u_decode (
		.cfg (cfg_q),
		.cur (state_q),
		.lvl (rx_level),
		.nxt (state_nxt),
		.res (res)
	);

	// Receiver state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= PH_WAIT;
			state_q.elapsed      <= '0;
			state_q.ms_left      <= IDLE_TIMEOUT_RST;
			state_q.symbol_level <= 1'b0;
			state_q.shift_byte   <= '0;
			state_q.bits_taken   <= '0;
			state_q.bytes_taken  <= '0;
		end else if (in_acc) begin
			state_q <= state_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else begin
			if (in_acc) begin
				out_q.valid <= res.valid;
			end else if (out_ready) begin
				out_q.valid <= 1'b0;
			end
			if (in_acc && res.valid) begin
				out_q.kind    <= res.kind;
				out_q.data    <= res.data;
				out_q.count   <= res.count;
				out_q.reason  <= res.reason;
				out_q.pending <= res.pending;
			end
		end
	end

	assign out_valid    = out_q.valid;
	assign result_kind  = out_q.kind;
	assign byte_data    = out_q.data;
	assign byte_count   = out_q.count;
	assign end_reason   = out_q.reason;
	assign pending_bits = out_q.pending;

	// Checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output register");

	a_byte_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == KIND_BYTE) |-> (end_reason == END_SYMBOL_TIMEOUT
		&& pending_bits == '0))
		else $error("byte result carries end fields");

	a_wait_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_WAIT) |-> (state_q.bits_taken == '0
		&& state_q.bytes_taken == '0 && state_q.shift_byte == '0))
		else $error("frame state left over while waiting");

	a_end_reloads_ms: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && res.valid && res.kind == KIND_END) |=>
		(state_q.ms_left == $past(cfg_q.idle_timeout) && state_q.phase == PH_WAIT))
		else $error("frame end did not reload idle wait");

endmodule

@@ tb/tb_vpw_frame_receiver.sv @@
// Self-checking testbench for the VPW frame receiver: drives line samples as ticks and
// checks every byte and frame-end result against a cycle-free decoder model.
// Depends on vpw_pkg and the vpw_frame_receiver RTL.
`timescale 1ns / 100ps

module tb_vpw_frame_receiver;

	import vpw_pkg::*;

	localparam int QuietLimit = 2000;

	typedef struct packed {
		logic               kind;
		logic [ByteW-1:0]   data;
		logic [ByteW-1:0]   count;
		end_reason_t        reason;
		logic [BitCntW-1:0] pending;
	} bus_event_t;

	// DUT inputs start known
	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                rx_level = 1'b0;
	logic                out_ready = 1'b0;
	logic                cfg_we = 1'b0;
	logic [RegIdxW-1:0]  cfg_index = '0;
	logic [TimeW-1:0]    cfg_data = '0;
	logic                in_ready;
	logic                out_valid;
	logic                result_kind;
	logic [ByteW-1:0]    byte_data;
	logic [ByteW-1:0]    byte_count;
	logic [1:0]          end_reason;
	logic [BitCntW-1:0]  pending_bits;

	// Register shadows
	logic [TimeW-1:0] sof_min_cfg, sof_max_cfg, glitch_cfg, long_min_cfg;
	logic [TimeW-1:0] timeout_cfg, tpm_cfg;
	logic [MsW-1:0]   idle_cfg;

	// Decoder state
	phase_t           rx_phase;
	logic [TimeW-1:0] rx_ticks;
	logic [MsW-1:0]   rx_ms_left;
	logic             rx_sym_level;
	logic [ByteW-1:0] rx_shift;
	logic [3:0]       rx_bits;
	logic [ByteW-1:0] rx_bytes;

	bus_event_t frame_events[$];
	int         fail_count = 0;
	int         tick_count = 0;
	int         quiet_cycles = 0;
	int         idle_pct = 0;
	int         stall_pct = 0;
	logic       bus_level = 1'b0;

	vpw_frame_receiver i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_level     (rx_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.byte_data    (byte_data),
		.byte_count   (byte_count),
		.end_reason   (end_reason),
		.pending_bits (pending_bits),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Decoder model
	// ---------------------------------------------------------------
	function automatic logic [TimeW-1:0] tick_inc(input logic [TimeW-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	task automatic clear_frame();
		rx_phase = PH_WAIT;
		rx_ticks = '0;
		rx_sym_level = 1'b0;
		rx_shift = '0;
		rx_bits = '0;
		rx_bytes = '0;
	endtask

	task automatic reset_model();
		sof_min_cfg = SOF_MIN_RST;
		sof_max_cfg = SOF_MAX_RST;
		glitch_cfg = GLITCH_RST;
		long_min_cfg = LONG_MIN_RST;
		timeout_cfg = SYMBOL_TIMEOUT_RST;
		tpm_cfg = TICKS_PER_MS_RST;
		idle_cfg = IDLE_TIMEOUT_RST;
		clear_frame();
		rx_ms_left = idle_cfg;
	endtask

	task automatic end_frame(input end_reason_t why, input logic [BitCntW-1:0] dropped);
		frame_events.push_back('{kind: KIND_END, data: '0, count: rx_bytes,
			reason: why, pending: dropped});
		clear_frame();
		rx_ms_left = idle_cfg;
	endtask

	// Symbol timeout check shared by the symbol and glitch phases
	task automatic count_symbol_tick();
		rx_ticks = tick_inc(rx_ticks);
		if (rx_ticks >= timeout_cfg) begin
			end_frame(END_SYMBOL_TIMEOUT, rx_bits[BitCntW-1:0]);
		end
	endtask

	task automatic decode_tick(input logic lvl);
		logic bitv;
		case (rx_phase)
			PH_WAIT: begin
				if (lvl) begin
					rx_phase = PH_SOF;
					rx_ticks = TimeW'(1);
				end else begin
					rx_ticks = tick_inc(rx_ticks);
					if (rx_ticks >= tpm_cfg) begin
						rx_ticks = '0;
						if (rx_ms_left != 0) rx_ms_left--;
						if (rx_ms_left == 0) end_frame(END_IDLE_TIMEOUT, '0);
					end
				end
			end
			PH_SOF: begin
				if (lvl) begin
					rx_ticks = tick_inc(rx_ticks);
					if (rx_ticks >= sof_max_cfg) end_frame(END_SOF_TOO_LONG, '0);
				end else if (rx_ticks < sof_min_cfg) begin
					// start pulse too short: back to waiting, ms budget kept
					clear_frame();
				end else begin
					rx_phase = PH_SYMBOL;
					rx_sym_level = 1'b0;
					rx_ticks = TimeW'(1);
				end
			end
			PH_SYMBOL: begin
				if (lvl == rx_sym_level) begin
					count_symbol_tick();
				end else if (rx_ticks < glitch_cfg) begin
					rx_phase = PH_GLITCH;
					count_symbol_tick();
				end else begin
					// long low / short high -> 1, short low / long high -> 0
					bitv = (rx_ticks >= long_min_cfg) ? ~rx_sym_level : rx_sym_level;
					rx_shift = {rx_shift[ByteW-2:0], bitv};
					rx_bits++;
					rx_sym_level = lvl;
					rx_ticks = TimeW'(1);
					if (rx_bits == 8) begin
						if (rx_bytes != '1) rx_bytes++;
						frame_events.push_back('{kind: KIND_BYTE, data: rx_shift,
							count: rx_bytes, reason: END_SYMBOL_TIMEOUT, pending: '0});
						rx_bits = '0;
						rx_shift = '0;
					end
				end
			end
			default: begin
				if (lvl == rx_sym_level) rx_phase = PH_SYMBOL;
				count_symbol_tick();
			end
		endcase
	endtask

	// ---------------------------------------------------------------
	// Stimulus helpers (all start and end on a falling edge)
	// ---------------------------------------------------------------
	task automatic send_tick(input logic lvl);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			rx_level <= 1'($urandom_range(1));
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_level <= lvl;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		decode_tick(lvl);
		tick_count++;
		@(negedge clk);
	endtask

	task automatic send_level(input logic lvl, input int unsigned n);
		repeat (n) send_tick(lvl);
	endtask

	// Hold off requests until every predicted result has been taken
	task automatic drain_events();
		in_valid <= 1'b0;
		while (frame_events.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [TimeW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_SOF_MIN:        sof_min_cfg = val;
			REG_SOF_MAX:        sof_max_cfg = val;
			REG_GLITCH:         glitch_cfg = val;
			REG_LONG_MIN:       long_min_cfg = val;
			REG_SYMBOL_TIMEOUT: timeout_cfg = val;
			REG_TICKS_PER_MS:   tpm_cfg = val;
			default:            idle_cfg = val[MsW-1:0];
		endcase
		@(negedge clk);
	endtask

	task automatic apply_timing(input logic [TimeW-1:0] smin, input logic [TimeW-1:0] smax,
			input logic [TimeW-1:0] glt, input logic [TimeW-1:0] lmin,
			input logic [TimeW-1:0] tmo, input logic [TimeW-1:0] tpm,
			input logic [TimeW-1:0] idle);
		drain_events();
		write_reg(REG_SOF_MIN, smin);
		write_reg(REG_SOF_MAX, smax);
		write_reg(REG_GLITCH, glt);
		write_reg(REG_LONG_MIN, lmin);
		write_reg(REG_SYMBOL_TIMEOUT, tmo);
		write_reg(REG_TICKS_PER_MS, tpm);
		write_reg(REG_IDLE_TIMEOUT, idle);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Random timing set that keeps short, long and start windows non-empty
	task automatic pick_timing();
		int unsigned g, lm, smin;
		g = $urandom_range(3);
		lm = g + 2 + $urandom_range(3);
		smin = $urandom_range(6, 1);
		apply_timing(TimeW'(smin), TimeW'(smin + 1 + $urandom_range(5)), TimeW'(g),
			TimeW'(lm), TimeW'(lm + 1 + $urandom_range(5)),
			TimeW'($urandom_range(8, 1)), TimeW'($urandom_range(6, 1)));
	endtask

	task automatic send_sof();
		send_level(1'b1, $urandom_range(sof_max_cfg - 1, (sof_min_cfg > 0) ? sof_min_cfg : 1));
		bus_level = 1'b0;
	endtask

	// One symbol; optionally with a one-tick blip that the glitch filter absorbs
	task automatic send_bit(input logic b, input bit glitchy);
		int unsigned len;
		logic lvl;
		lvl = bus_level;
		if (b ^ lvl) begin
			len = $urandom_range(timeout_cfg - 1, long_min_cfg);
		end else begin
			len = $urandom_range(long_min_cfg - 1, (glitch_cfg > 1) ? glitch_cfg : 1);
		end
		if (glitchy && len >= 3 && glitch_cfg >= 2) begin
			send_tick(lvl);
			send_tick(~lvl);
			send_level(lvl, len - 2);
		end else begin
			send_level(lvl, len);
		end
		bus_level = ~lvl;
	endtask

	task automatic send_byte(input logic [ByteW-1:0] val, input bit glitchy);
		for (int i = ByteW - 1; i >= 0; i--) send_bit(val[i], glitchy);
	endtask

	task automatic send_loose_bits(input int n, input bit glitchy);
		repeat (n) send_bit(1'($urandom_range(1)), glitchy);
	endtask

	// Level held to the symbol timeout closes the frame
	task automatic send_eof();
		send_level(bus_level, (timeout_cfg > 2) ? timeout_cfg : 2);
	endtask

	task automatic settle_to_wait();
		while (rx_phase != PH_WAIT) send_tick(1'b0);
	endtask

	// ---------------------------------------------------------------
	// Result checker
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		bus_event_t want;
		if (arst_n && out_valid && out_ready) begin
			if (frame_events.size() == 0) begin
				$error("unexpected result: kind %0d data %0h count %0d reason %0d pending %0d",
					result_kind, byte_data, byte_count, end_reason, pending_bits);
				fail_count++;
			end else begin
				want = frame_events.pop_front();
				if (result_kind !== want.kind) begin
					$error("result_kind: expected %0d, got %0d", want.kind, result_kind);
					fail_count++;
				end
				if (byte_data !== want.data) begin
					$error("byte_data: expected %0h, got %0h", want.data, byte_data);
					fail_count++;
				end
				if (byte_count !== want.count) begin
					$error("byte_count: expected %0d, got %0d", want.count, byte_count);
					fail_count++;
				end
				if (end_reason !== want.reason) begin
					$error("end_reason: expected %0d, got %0d", want.reason, end_reason);
					fail_count++;
				end
				if (pending_bits !== want.pending) begin
					$error("pending_bits: expected %0d, got %0d", want.pending, pending_bits);
					fail_count++;
				end
			end
		end
	end

	// Receiver back-pressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: too long without any request taken on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QuietLimit) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// Frame at reset timing, extreme byte values and dropped partial bits
	task automatic test_default_frame();
		idle_pct = 0;
		stall_pct = 0;
		send_sof();
		send_byte(8'hA5, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_loose_bits(3, 1'b0);
		send_eof();
	endtask

	// Start pulse too short, exactly minimum, too long; idle limit
	task automatic test_start_pulse();
		idle_pct = 73;
		stall_pct = 0;
		apply_timing(6, 10, 2, 5, 9, 4, 3);
		send_level(1'b1, 3);
		send_tick(1'b0);
		send_level(1'b1, 6);
		send_byte(8'h5A, 1'b0);
		send_eof();
		send_level(1'b1, 10);
		send_level(1'b0, 13);
		// short pulse in the middle of the idle wait keeps the ms budget
		send_level(1'b0, 5);
		send_level(1'b1, 2);
		send_level(1'b0, 10);
	endtask

	// Zero tick count, zero idle limit, largest values, high bits on the 8-bit register
	task automatic test_idle_limit();
		idle_pct = 0;
		stall_pct = 73;
		apply_timing(6, 10, 2, 5, 9, 0, 0);
		send_level(1'b0, 3);
		apply_timing(6, 10, 2, 5, 9, 1023, 1);
		send_level(1'b0, 1025);
		apply_timing(6, 10, 2, 5, 9, 1, 10'h3FF);
		send_level(1'b0, 257);
	endtask

	// All limits zero, then all limits at full scale
	task automatic test_register_extremes();
		idle_pct = 11;
		stall_pct = 11;
		apply_timing(0, 0, 0, 0, 0, 0, 0);
		send_level(1'b1, 2);
		send_tick(1'b1);
		send_level(1'b0, 2);
		repeat (24) send_tick(1'($urandom_range(1)));
		apply_timing(1023, 1023, 1023, 1023, 1023, 1023, 10'h3FF);
		send_level(1'b1, 1023);
		// every change absorbed by the glitch filter until the timeout
		apply_timing(1, 1023, 1023, 512, 1023, 1023, 255);
		send_level(1'b1, 2);
		send_tick(1'b0);
		repeat (1022) send_tick(1'($urandom_range(1)));
	endtask

	task automatic test_glitch_filter();
		idle_pct = 0;
		stall_pct = 0;
		apply_timing(6, 10, 3, 6, 12, 4, 3);
		send_sof();
		send_byte(8'hC3, 1'b1);
		send_byte(8'h3C, 1'b1);
		send_loose_bits(5, 1'b1);
		send_eof();
		// level change held as a glitch until the symbol timeout
		send_sof();
		send_tick(1'b0);
		send_level(1'b1, 12);
	endtask

	task automatic test_byte_count_saturation();
		idle_pct = 0;
		stall_pct = 0;
		apply_timing(1, 2, 0, 2, 3, 8, 8);
		send_sof();
		repeat (260) send_byte(8'($urandom_range(255)), 1'b0);
		send_loose_bits(7, 1'b0);
		send_eof();
	endtask

	task automatic random_action();
		int unsigned pick;
		bit glitchy;
		pick = $urandom_range(99);
		glitchy = 1'($urandom_range(1));
		if (pick < 86) settle_to_wait();
		if (pick < 60) begin
			send_level(1'b0, $urandom_range(3));
			send_sof();
			repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)), glitchy);
			send_loose_bits($urandom_range(7), glitchy);
			send_eof();
		end else if (pick < 70) begin
			if (sof_min_cfg > 1) send_level(1'b1, $urandom_range(sof_min_cfg - 1, 1));
			send_tick(1'b0);
		end else if (pick < 78) begin
			send_level(1'b1, sof_max_cfg + $urandom_range(2));
		end else if (pick < 86) begin
			send_level(1'b0, $urandom_range(tpm_cfg * idle_cfg + 2, 1));
		end else begin
			repeat ($urandom_range(30, 1)) send_tick(1'($urandom_range(1)));
		end
		pick = $urandom_range(99);
		if (pick < 6) begin
			pick_timing();
		end else if (pick < 14) begin
			drain_events();
		end
	endtask

	task automatic test_random_traffic();
		int start_ticks;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 73; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 73; end
				default: begin idle_pct = 11; stall_pct = 11; end
			endcase
			pick_timing();
			start_ticks = tick_count;
			while (tick_count - start_ticks < 125) begin
				random_action();
			end
		end
	endtask

	initial begin
		reset_model();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_default_frame();
		test_start_pulse();
		test_idle_limit();
		test_register_extremes();
		test_glitch_filter();
		test_byte_count_saturation();
		test_random_traffic();
		drain_events();
		repeat (10) @(negedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
